### sv/priority_process_scheduler_defines.svh
// ----------------------------------------------------------------------------
// priority_process_scheduler_defines
// Assertion macros used by the scheduler datapath (pps_dp).
// ----------------------------------------------------------------------------
`ifndef PRIORITY_PROCESS_SCHEDULER_DEFINES_SVH
`define PRIORITY_PROCESS_SCHEDULER_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define PPS_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Implication checked at every clock edge out of reset.
`define PPS_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### sv/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Shared constants, command codes and control structs of the scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

	localparam int PPS_NUM_PROCS  = 8;
	localparam int PPS_NUM_LEVELS = 5;

	// command kinds
	localparam logic [2:0] KIND_ADD     = 3'd0;
	localparam logic [2:0] KIND_RELEASE = 3'd1;
	localparam logic [2:0] KIND_SETPRI  = 3'd2;
	localparam logic [2:0] KIND_GETPRI  = 3'd3;
	localparam logic [2:0] KIND_BLOCK   = 3'd4;
	localparam logic [2:0] KIND_UNBLOCK = 3'd5;
	localparam logic [2:0] KIND_MKREADY = 3'd6;

	// process status codes
	localparam logic [1:0] PST_NEW     = 2'd0;
	localparam logic [1:0] PST_READY   = 2'd1;
	localparam logic [1:0] PST_EXEC    = 2'd2;
	localparam logic [1:0] PST_BLOCKED = 2'd3;

	typedef struct packed {
		logic load;   // capture item, restart scan
		logic step;   // one scan step
		logic apply;  // commit command, load result register
	} pps_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic out_busy;
	} pps_sts_t;

endpackage

### sv/pps_ctrl.sv
// ----------------------------------------------------------------------------
// pps_ctrl
// Sequencer: capture, scan all process slots, commit.
// ----------------------------------------------------------------------------
module pps_ctrl import pps_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  pps_sts_t sts,
	output pps_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_APPLY = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		in_ready  = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.step = 1'b1;
				if (sts.scan_last) state_nxt = ST_APPLY;
			end
			ST_APPLY: begin
				if (!sts.out_busy) begin
					cmd.apply = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_nxt;
	end

endmodule

### sv/pps_dp.sv
// ----------------------------------------------------------------------------
// pps_dp
// Process table, queue membership, age matrix, best-entry scan, result reg.
// ----------------------------------------------------------------------------
`include "priority_process_scheduler_defines.svh"

module pps_dp import pps_pkg::*; #(
	parameter int NUM_PROCS  = PPS_NUM_PROCS,
	parameter int NUM_LEVELS = PPS_NUM_LEVELS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  pps_cmd_t   cmd,
	output pps_sts_t   sts,
	input  logic [2:0] in_kind,
	input  logic [2:0] in_pid,
	input  logic [2:0] in_prio,
	input  logic       out_ready,
	output logic       out_valid,
	output logic       out_status,
	output logic [2:0] out_value,
	output logic [2:0] out_run,
	output logic       out_run_valid
);

	localparam int IW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
	localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_PROCS - 1);

	// command registers
	logic [2:0] kind_q, pid_q, npr_q;

	// process table
	logic [LW-1:0]      prio_q [NUM_PROCS];
	logic [1:0]         stat_q [NUM_PROCS];
	logic [NUM_PROCS-1:0] in_r_q, in_b_q;
	// older_q[a][b]: a was queued before b
	logic [NUM_PROCS-1:0] older_q [NUM_PROCS];
	logic [IW-1:0]      run_q;
	logic               runf_q;

	// scan state
	logic [IW-1:0] cnt_q;
	logic          rb_v_q, bb_v_q;
	logic [IW-1:0] rb_pid_q, bb_pid_q;
	logic [LW-1:0] rb_lvl_q, bb_lvl_q;

	logic [IW-1:0] pidx;
	logic [LW-1:0] npr_l;
	logic          pid_ok, prio_ok, is_run, set_ok, set_chg, mv_r, mv_b;

	assign pidx    = IW'(pid_q);
	assign npr_l   = LW'(npr_q);
	assign pid_ok  = 32'(pid_q) < NUM_PROCS;
	assign prio_ok = 32'(npr_q) < NUM_LEVELS;
	assign is_run  = pid_ok && runf_q && (run_q == pidx);
	assign set_ok  = pid_ok && prio_ok && (pid_q != 3'd0) && (32'(npr_q) != NUM_LEVELS - 1);
	assign set_chg = (kind_q == KIND_SETPRI) && set_ok && (prio_q[pidx] != npr_l);
	assign mv_r    = set_chg && (stat_q[pidx] == PST_READY) && in_r_q[pidx];
	assign mv_b    = set_chg && (stat_q[pidx] == PST_BLOCKED) && in_b_q[pidx];

	// one slot per scan step; a ready process being moved by set priority is left out of the ready scan
	logic [LW-1:0] cur_lvl;
	logic          r_better, b_better;

	assign cur_lvl  = prio_q[cnt_q];
	assign r_better = in_r_q[cnt_q] && !(mv_r && cnt_q == pidx) &&
		(!rb_v_q || cur_lvl < rb_lvl_q ||
		(cur_lvl == rb_lvl_q && older_q[cnt_q][rb_pid_q]));
	assign b_better = in_b_q[cnt_q] &&
		(!bb_v_q || cur_lvl < bb_lvl_q ||
		(cur_lvl == bb_lvl_q && older_q[cnt_q][bb_pid_q]));

	assign sts.scan_last = (cnt_q == LAST_IDX);
	assign sts.out_busy  = out_valid && !out_ready;

	// commit decode
	logic          err;
	logic [2:0]    val;
	logic          wr_prio;
	logic          sa_en, sb_en;
	logic [IW-1:0] sa_idx, sb_idx;
	logic [1:0]    sa_val, sb_val;
	logic          rclr_en, bclr_en;
	logic [IW-1:0] rclr_idx, bclr_idx;
	logic          pa_en, pa_rdy, pb_en;
	logic [IW-1:0] pa_idx, pb_idx;
	logic          run_en;
	logic [IW-1:0] run_new;
	logic          rel_go, p_wins;
	logic [IW-1:0] nxt;

	always_comb begin
		err = 1'b0;  val = 3'd0;  wr_prio = 1'b0;
		sa_en = 1'b0; sa_idx = pidx; sa_val = PST_NEW;
		sb_en = 1'b0; sb_idx = pidx; sb_val = PST_NEW;
		rclr_en = 1'b0; rclr_idx = pidx;
		bclr_en = 1'b0; bclr_idx = pidx;
		pa_en = 1'b0; pa_idx = pidx; pa_rdy = 1'b1;
		pb_en = 1'b0; pb_idx = run_q;
		run_en = 1'b0; run_new = run_q;
		rel_go = 1'b0;
		// moved process joins its new level as youngest, wins only on a better level
		p_wins = mv_r && (!rb_v_q || npr_l < rb_lvl_q);
		nxt    = p_wins ? pidx : rb_pid_q;
		case (kind_q)
			KIND_ADD: begin
				if (!pid_ok || !prio_ok || is_run || in_r_q[pidx] || in_b_q[pidx]) begin
					err = 1'b1;
				end else begin
					wr_prio = 1'b1;
					sa_en = 1'b1; sa_val = PST_NEW;
					pa_en = 1'b1;
				end
			end
			KIND_RELEASE: begin
				if (!rb_v_q) err = 1'b1;
				else rel_go = 1'b1;
			end
			KIND_SETPRI: begin
				if (!set_ok) begin
					err = 1'b1;
				end else if (set_chg) begin
					if (mv_r || mv_b) wr_prio = 1'b1;
					if (mv_b) begin
						pa_en = 1'b1; pa_rdy = 1'b0;
					end
					if (mv_r && !p_wins) pa_en = 1'b1;
					rel_go = rb_v_q || mv_r;
				end
			end
			KIND_GETPRI: begin
				if (!pid_ok) err = 1'b1;
				else val = 3'(prio_q[pidx]);
			end
			KIND_BLOCK: begin
				if (!pid_ok) begin
					err = 1'b1;
				end else begin
					rclr_en = 1'b1;
					sa_en = 1'b1; sa_val = PST_BLOCKED;
					if (!in_b_q[pidx]) begin
						pa_en = 1'b1; pa_rdy = 1'b0;
					end
				end
			end
			KIND_UNBLOCK: begin
				if (!bb_v_q) begin
					err = 1'b1;
				end else begin
					val = 3'(bb_pid_q);
					bclr_en = 1'b1; bclr_idx = bb_pid_q;
					sa_en = 1'b1; sa_idx = bb_pid_q;
					if (runf_q && run_q == bb_pid_q) begin
						sa_val = PST_EXEC;
					end else begin
						sa_val = PST_READY;
						if (!in_r_q[bb_pid_q]) begin
							pa_en = 1'b1; pa_idx = bb_pid_q;
						end
					end
				end
			end
			KIND_MKREADY: begin
				if (!pid_ok || is_run) begin
					err = 1'b1;
				end else begin
					bclr_en = 1'b1;
					sa_en = 1'b1; sa_val = PST_READY;
					if (!in_r_q[pidx]) pa_en = 1'b1;
				end
			end
			default: err = 1'b1;
		endcase
		if (rel_go) begin
			rclr_en = 1'b1; rclr_idx = nxt;
			// previous process goes back to ready unless blocked
			if (runf_q && stat_q[run_q] != PST_BLOCKED) begin
				sa_en = 1'b1; sa_idx = run_q; sa_val = PST_READY;
				pb_en = 1'b1;
			end
			sb_en = 1'b1; sb_idx = nxt; sb_val = PST_EXEC;
			run_en = 1'b1; run_new = nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= in_kind;
			pid_q  <= in_pid;
			npr_q  <= in_prio;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			rb_v_q <= 1'b0;
			bb_v_q <= 1'b0;
		end else if (cmd.load) begin
			cnt_q  <= '0;
			rb_v_q <= 1'b0;
			bb_v_q <= 1'b0;
		end else if (cmd.step) begin
			cnt_q <= cnt_q + 1'b1;
			if (r_better) begin
				rb_v_q <= 1'b1;
			end
			if (b_better) begin
				bb_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			if (r_better) begin
				rb_pid_q <= cnt_q;
				rb_lvl_q <= cur_lvl;
			end
			if (b_better) begin
				bb_pid_q <= cnt_q;
				bb_lvl_q <= cur_lvl;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PROCS; i++) begin
				prio_q[i] <= '0;
				stat_q[i] <= PST_NEW;
			end
			in_r_q <= '0;
			in_b_q <= '0;
			run_q  <= '0;
			runf_q <= 1'b0;
		end else if (cmd.apply) begin
			if (wr_prio) prio_q[pidx] <= npr_l;
			if (sa_en) stat_q[sa_idx] <= sa_val;
			if (sb_en) stat_q[sb_idx] <= sb_val;
			if (rclr_en) in_r_q[rclr_idx] <= 1'b0;
			if (bclr_en) in_b_q[bclr_idx] <= 1'b0;
			if (pa_en) begin
				if (pa_rdy) in_r_q[pa_idx] <= 1'b1;
				else in_b_q[pa_idx] <= 1'b1;
			end
			if (pb_en) in_r_q[pb_idx] <= 1'b1;
			if (run_en) begin
				run_q  <= run_new;
				runf_q <= 1'b1;
			end
		end
	end

	// age matrix: a newly queued process is younger than all others;
	// the requeued running process lands behind a process queued by the same item
	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			for (int a = 0; a < NUM_PROCS; a++) begin
				for (int b = 0; b < NUM_PROCS; b++) begin
					if (pb_en && IW'(b) == pb_idx) older_q[a][b] <= 1'b1;
					else if (pb_en && IW'(a) == pb_idx) older_q[a][b] <= 1'b0;
					else if (pa_en && IW'(b) == pa_idx) older_q[a][b] <= 1'b1;
					else if (pa_en && IW'(a) == pa_idx) older_q[a][b] <= 1'b0;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.apply) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			out_status    <= err;
			out_value     <= val;
			out_run       <= 3'(run_new);
			out_run_valid <= runf_q || run_en;
		end
	end

	`PPS_ASSERT_ALWAYS(a_one_queue, (in_r_q & in_b_q) == '0, "pid in ready and blocked queue")
	`PPS_ASSERT_IMPLY(a_run_not_ready, runf_q, !in_r_q[run_q], "running pid sits in ready queue")
	`PPS_ASSERT_IMPLY(a_commit_free, cmd.apply, !(out_valid && !out_ready), "result overwritten")

endmodule

### sv/priority_process_scheduler.sv
// ----------------------------------------------------------------------------
// priority_process_scheduler: fixed-priority FIFO process scheduler
// Items are taken one at a time: the scan visits one process slot a cycle,
// then the commit waits for a free result register before the next accept.
// arst_n clears all queues, priorities, status and the running process.
// ----------------------------------------------------------------------------
module priority_process_scheduler import pps_pkg::*; #(
	parameter int NUM_PROCS  = PPS_NUM_PROCS,
	parameter int NUM_LEVELS = PPS_NUM_LEVELS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [2:0] process_id, [5:3] new_priority, pad
	input  logic [2:0] s_tuser,   // [2:0] kind
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [2:0] result_value, [5:3] running_process,
	                              // [6] running_valid, pad
	output logic       m_tuser    // [0] status
);

	// Controller steps: capture item, scan every slot for the best ready
	// and best blocked entry, then commit once the result register is free.
	pps_cmd_t cmd;
	pps_sts_t sts;

	logic [2:0] res_value, res_run;
	logic       res_run_valid;

	pps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pps_dp #(
		.NUM_PROCS  (NUM_PROCS),
		.NUM_LEVELS (NUM_LEVELS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_kind       (s_tuser),
		.in_pid        (s_tdata[2:0]),
		.in_prio       (s_tdata[5:3]),
		.out_ready     (m_tready),
		.out_valid     (m_tvalid),
		.out_status    (m_tuser),
		.out_value     (res_value),
		.out_run       (res_run),
		.out_run_valid (res_run_valid)
	);

	// result item packed low field first
	assign m_tdata = {1'b0, res_run_valid, res_run, res_value};

endmodule
